// File: sv/ltc_pkg.sv
// ----------------------------------------------------------------------------
// ltc_pkg: shared types for the timestamp LRU handle cache
// Field types, the controller state encoding and the command/status structs
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ltc_pkg;

    typedef logic [30:0] t_icon;
    typedef logic [2:0]  t_size;
    typedef logic [31:0] t_frame;
    typedef logic [47:0] t_handle;
    typedef logic [33:0] t_key;
    typedef logic [3:0]  t_slot;
    typedef logic [4:0]  t_limit;

    localparam t_limit LIMIT_RESET = 5'd16;
    localparam t_frame STAMP_MAX   = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;   // latch a new request and clear the scan results
        logic rd;      // read the entry at the scan address and advance
        logic commit;  // update the stores and load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;  // no entries in use
        logic addr_last;   // scan address points at the last entry in use
        logic out_busy;    // result register holds a result not yet taken
    } t_sts;

endpackage

// File: sv/ltc_req_if.sv
// ----------------------------------------------------------------------------
// ltc_req_if: request channel of the handle cache
// Valid/ready handshake carrying the lookup key, frame and candidate handle.
// ----------------------------------------------------------------------------
interface ltc_req_if;
    import ltc_pkg::*;

    logic    valid;
    logic    ready;
    t_icon   icon_index;
    t_size   size_class;
    t_frame  current_frame;
    t_handle new_handle;

    modport source (output valid, icon_index, size_class, current_frame, new_handle,
                    input ready);
    modport sink   (input valid, icon_index, size_class, current_frame, new_handle,
                    output ready);
endinterface

// File: sv/ltc_rsp_if.sv
// ----------------------------------------------------------------------------
// ltc_rsp_if: response channel of the handle cache
// Valid/ready handshake carrying one lookup result.
// ----------------------------------------------------------------------------
interface ltc_rsp_if;
    import ltc_pkg::*;

    logic    valid;
    logic    ready;
    t_handle handle_out;
    logic    was_hit;
    t_slot   slot_used;
    logic    did_evict;
    t_handle evicted_handle;

    modport source (output valid, handle_out, was_hit, slot_used, did_evict,
                    evicted_handle, input ready);
    modport sink   (input valid, handle_out, was_hit, slot_used, did_evict,
                    evicted_handle, output ready);
endinterface

// File: sv/ltc_ctrl.sv
// ----------------------------------------------------------------------------
// ltc_ctrl: sequencing controller of the handle cache
// Accepts a request, steps the datapath through the entry scan and commits.
// ----------------------------------------------------------------------------
module ltc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output ltc_pkg::t_cmd o_cmd,
    input  ltc_pkg::t_sts i_sts
);
    import ltc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_sts.count_zero ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last read result is compared during this cycle.
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/ltc_datapath.sv
// ----------------------------------------------------------------------------
// ltc_datapath: entry stores, scan compare and result register
// Holds the key, handle and stamp memories, tracks the first match and the
// oldest entry over the scan, and applies the hit, append or replace update.
// ----------------------------------------------------------------------------
module ltc_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ltc_pkg::t_icon   i_icon_index,
    input  ltc_pkg::t_size   i_size_class,
    input  ltc_pkg::t_frame  i_current_frame,
    input  ltc_pkg::t_handle i_new_handle,
    input  logic             i_cfg_we,
    input  ltc_pkg::t_limit  i_cfg_wdata,
    input  ltc_pkg::t_cmd    i_cmd,
    output ltc_pkg::t_sts    o_sts,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output ltc_pkg::t_handle o_handle_out,
    output logic             o_was_hit,
    output ltc_pkg::t_slot   o_slot_used,
    output logic             o_did_evict,
    output ltc_pkg::t_handle o_evicted_handle
);
    import ltc_pkg::*;

    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CW > 5) ? CW : 5;

    // Entry stores.
    t_key    mem_key    [ENTRIES];
    t_handle mem_handle [ENTRIES];
    t_frame  mem_stamp  [ENTRIES];

    t_limit          r_limit;
    logic [CW-1:0]   r_count;

    // Latched request.
    t_key            r_key;
    t_frame          r_frame;
    t_handle         r_new_handle;

    // Scan address and registered read port.
    logic [AW-1:0]   r_addr;
    logic            r_rd_valid;
    logic [AW-1:0]   r_rd_idx;
    t_key            r_rd_key;
    t_handle         r_rd_handle;
    t_frame          r_rd_stamp;

    // Scan results.
    logic            r_hit;
    logic [AW-1:0]   r_hit_idx;
    t_handle         r_hit_handle;
    t_frame          r_oldest;
    logic [AW-1:0]   r_best;
    t_handle         r_best_handle;

    // Result register.
    logic            r_out_valid;
    t_handle         r_handle_out;
    logic            r_was_hit;
    t_slot           r_slot_used;
    logic            r_did_evict;
    t_handle         r_evicted_handle;

    logic [CMP_W-1:0] eff_limit;
    logic             can_append;
    logic             do_write;
    logic [AW-1:0]    wr_slot;
    logic [AW+3:0]    slot_ext;

    always_comb begin
        if (r_limit == '0) begin
            eff_limit = CMP_W'(1);
        end else if (CMP_W'(r_limit) > CMP_W'(ENTRIES)) begin
            eff_limit = CMP_W'(ENTRIES);
        end else begin
            eff_limit = CMP_W'(r_limit);
        end
    end

    assign can_append = CMP_W'(r_count) < eff_limit;
    assign do_write   = i_cmd.commit && !r_hit && (r_new_handle != '0);
    assign wr_slot    = can_append ? r_count[AW-1:0] : r_best;

    // Slot numbers are reported modulo 16.
    always_comb begin
        if (r_hit) begin
            slot_ext = {4'b0000, r_hit_idx};
        end else begin
            slot_ext = {4'b0000, wr_slot};
        end
    end

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            mem_key[wr_slot]    <= r_key;
            mem_handle[wr_slot] <= r_new_handle;
            mem_stamp[wr_slot]  <= r_frame;
        end else if (i_cmd.commit && r_hit) begin
            mem_stamp[r_hit_idx] <= r_frame;
        end
        r_rd_key    <= mem_key[r_addr];
        r_rd_handle <= mem_handle[r_addr];
        r_rd_stamp  <= mem_stamp[r_addr];
        r_rd_idx    <= r_addr;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_count     <= '0;
            r_rd_valid  <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
            r_addr      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_rd_valid <= i_cmd.rd;
            if (i_cmd.start) begin
                r_addr <= '0;
            end else if (i_cmd.rd) begin
                r_addr <= r_addr + AW'(1);
            end
            if (i_cmd.start) begin
                r_hit <= 1'b0;
            end else if (r_rd_valid && !r_hit && (r_rd_key == r_key)) begin
                r_hit <= 1'b1;
            end
            if (do_write && can_append) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key        <= {i_size_class, i_icon_index};
            r_frame      <= i_current_frame;
            r_new_handle <= i_new_handle;
            r_oldest     <= STAMP_MAX;
            r_best       <= '0;
        end
        if (r_rd_valid) begin
            if (!r_hit && (r_rd_key == r_key)) begin
                r_hit_idx    <= r_rd_idx;
                r_hit_handle <= r_rd_handle;
            end
            // Entry zero is always taken as the first candidate so that its
            // handle is at hand when no stamp lies below the maximum.
            if ((r_rd_stamp < r_oldest) || (r_rd_idx == '0)) begin
                r_oldest      <= r_rd_stamp;
                r_best        <= r_rd_idx;
                r_best_handle <= r_rd_handle;
            end
        end
        if (i_cmd.commit) begin
            if (r_hit) begin
                r_handle_out     <= r_hit_handle;
                r_was_hit        <= 1'b1;
                r_slot_used      <= slot_ext[3:0];
                r_did_evict      <= 1'b0;
                r_evicted_handle <= '0;
            end else if (r_new_handle == '0) begin
                r_handle_out     <= '0;
                r_was_hit        <= 1'b0;
                r_slot_used      <= '0;
                r_did_evict      <= 1'b0;
                r_evicted_handle <= '0;
            end else begin
                r_handle_out     <= r_new_handle;
                r_was_hit        <= 1'b0;
                r_slot_used      <= slot_ext[3:0];
                r_did_evict      <= !can_append;
                r_evicted_handle <= can_append ? '0 : r_best_handle;
            end
        end
    end

    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.addr_last  = (CW'(r_addr) == (r_count - CW'(1)));
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_handle_out     = r_handle_out;
    assign o_was_hit        = r_was_hit;
    assign o_slot_used      = r_slot_used;
    assign o_did_evict      = r_did_evict;
    assign o_evicted_handle = r_evicted_handle;

endmodule

// File: sv/lru_timestamp_handle_cache.sv
// Requests are taken one at a time: a new request is accepted only after the previous one has
// committed. The entries in use are scanned through the single read port of the entry stores,
// visited one entry per cycle.
// Reset: synchronous, active low; clears the entry count, the result valid flag and sets
// the entry limit to 16. The entry stores are not cleared; only written entries are read.
// ----------------------------------------------------------------------------
// lru_timestamp_handle_cache: fully associative handle cache, timestamp LRU
// Looks up an (icon, size class) key; hits refresh the stamp, misses with a nonzero new
// handle append or replace the entry with the oldest stamp and report its handle.
// ----------------------------------------------------------------------------
module lru_timestamp_handle_cache #(
    parameter int ENTRIES = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  ltc_pkg::t_limit i_cfg_wdata,
    ltc_req_if.sink         i_req,
    ltc_rsp_if.source       o_rsp
);
    import ltc_pkg::*;

    // The controller only sequences; all state of the cache itself lives in
    // the datapath. They talk through one command and one status struct.
    t_cmd cmd;
    t_sts sts;

    // The controller takes a request in its idle state. The request fields
    // are latched by the datapath on the start command, so the channel is
    // free again as soon as the transfer completes.
    ltc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // The datapath scans entries 0 to count-1 through a registered read
    // port. For every entry it checks the key (first match wins) and tracks
    // the strictly smallest stamp, lowest index on ties. On commit it writes
    // the stores and loads the result register, which holds its result
    // until the response transfer; a new request may already be scanning.
    ltc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_icon_index     (i_req.icon_index),
        .i_size_class     (i_req.size_class),
        .i_current_frame  (i_req.current_frame),
        .i_new_handle     (i_req.new_handle),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_out_valid      (o_rsp.valid),
        .i_out_ready      (o_rsp.ready),
        .o_handle_out     (o_rsp.handle_out),
        .o_was_hit        (o_rsp.was_hit),
        .o_slot_used      (o_rsp.slot_used),
        .o_did_evict      (o_rsp.did_evict),
        .o_evicted_handle (o_rsp.evicted_handle)
    );

    // A new result appears only right after a commit.
    a_rose_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(cmd.commit))
        else $error("result valid rose without a commit");

    // A commit never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !(o_rsp.valid && !o_rsp.ready))
        else $error("commit while result register busy");

    // A hit never replaces an entry.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.was_hit && o_rsp.did_evict))
        else $error("hit reported together with an eviction");

    // No request is taken while a scan or commit is in progress.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |=> !i_req.ready)
        else $error("request channel ready during a lookup");

endmodule
